FILE: hdl/three_class_stable_priority_queue_macros.svh
// Assertion helpers shared by the queue modules.
`ifndef THREE_CLASS_STABLE_PRIORITY_QUEUE_MACROS_SVH
`define THREE_CLASS_STABLE_PRIORITY_QUEUE_MACROS_SVH

// Check cons in the same cycle as ante.
`define TSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue assertion failed");

// Check cons in the cycle after ante.
`define TSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue assertion failed");

`endif

FILE: hdl/tspq_pkg.sv
package tspq_pkg;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_SERVED   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [1:0] CLS_GENERAL = 2'd0;
    localparam logic [1:0] CLS_SENIOR  = 2'd1;
    localparam logic [1:0] CLS_VIP     = 2'd2;
    localparam logic [1:0] CLS_INVALID = 2'd3;

    localparam int NUM_CLASSES = 3;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] cls;
    } t_q_cmd;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] head_cls;
    } t_q_flags;

endpackage

FILE: hdl/three_class_stable_priority_queue.sv
// Enqueue or rejected item: result registered in the cycle after acceptance.
// Served dequeue: one synchronous read of the entry memory, then the id is registered.
// One enqueue per cycle when output is free; a served dequeue holds input until served.
// Reset clears class pointers, counts and the output valid flag; the entry
// memory is not cleared and needs no sweep, so items are taken at once.
`include "three_class_stable_priority_queue_macros.svh"

module three_class_stable_priority_queue #(
    parameter int DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_entry_id,
    input  logic [1:0]  i_entry_class,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_served_id,
    output logic [1:0]  o_served_class,
    output logic [7:0]  o_occupancy
);
    import tspq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(NUM_CLASSES * DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic          r_out_valid;
    t_status       r_status;
    logic [15:0]   r_id;
    logic [1:0]    r_cls;
    logic [7:0]    r_occ;
    logic [1:0]    r_pend_cls;
    logic [7:0]    r_pend_occ;

    t_q_cmd        cmd;
    t_q_flags      flags;
    logic [CW-1:0] total;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    logic          out_free;
    logic          in_acc;
    logic          is_enq;
    logic          bad_cls;
    logic          enq_ok;
    logic          deq_ok;
    logic          load_now;
    logic          load_read;
    t_status       now_status;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_enq  = (i_action == ACT_ENQ);
    assign bad_cls = (i_entry_class == CLS_INVALID);
    assign enq_ok  = in_acc && is_enq && !bad_cls && !flags.full;
    assign deq_ok  = in_acc && !is_enq && !flags.empty;

    assign cmd.push = enq_ok;
    assign cmd.pop  = deq_ok;
    assign cmd.cls  = i_entry_class;

    tspq_track #(
        .DEPTH(DEPTH)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_flags (flags),
        .o_total (total),
        .o_waddr (waddr),
        .o_raddr (raddr)
    );

    tspq_ram #(
        .WIDTH(16),
        .DEPTH(NUM_CLASSES * DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (enq_ok),
        .i_waddr (waddr),
        .i_wdata (i_entry_id),
        .i_re    (deq_ok),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (!is_enq) begin
            now_status = ST_EMPTY;
        end else if (bad_cls) begin
            now_status = ST_INVALID;
        end else if (flags.full) begin
            now_status = ST_FULL;
        end else begin
            now_status = ST_ENQUEUED;
        end
    end

    assign load_now  = in_acc && !deq_ok;
    assign load_read = (r_state == S_READ) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (deq_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_now || load_read) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the served class and occupancy until the memory returns the id.
    always_ff @(posedge i_clk) begin
        if (deq_ok) begin
            r_pend_cls <= flags.head_cls;
            r_pend_occ <= 8'(total - CW'(1));
        end
        if (load_now) begin
            r_status <= now_status;
            r_id     <= '0;
            r_cls    <= '0;
            r_occ    <= enq_ok ? 8'(total + CW'(1)) : 8'(total);
        end else if (load_read) begin
            r_status <= ST_SERVED;
            r_id     <= rdata;
            r_cls    <= r_pend_cls;
            r_occ    <= r_pend_occ;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_served_id    = r_id;
    assign o_served_class = r_cls;
    assign o_occupancy    = r_occ;

    `TSPQ_ASSERT_NEXT(a_deq_waits_read, i_clk, i_rst_n, deq_ok, r_state == S_READ && o_in_stall)
    `TSPQ_ASSERT_NOW(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `TSPQ_ASSERT_NEXT(a_read_loads_served, i_clk, i_rst_n, load_read, r_out_valid && r_status == ST_SERVED)

endmodule

FILE: hdl/tspq_ram.sv
module tspq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tspq_track.sv
`include "three_class_stable_priority_queue_macros.svh"

module tspq_track #(
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  tspq_pkg::t_q_cmd                         i_cmd,
    output tspq_pkg::t_q_flags                       o_flags,
    output logic [$clog2(DEPTH+1)-1:0]               o_total,
    output logic [$clog2(tspq_pkg::NUM_CLASSES*DEPTH)-1:0] o_waddr,
    output logic [$clog2(tspq_pkg::NUM_CLASSES*DEPTH)-1:0] o_raddr
);
    import tspq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(NUM_CLASSES * DEPTH);

    logic [PW-1:0] r_head [NUM_CLASSES];
    logic [PW-1:0] r_tail [NUM_CLASSES];
    logic [CW-1:0] r_cnt  [NUM_CLASSES];
    logic [CW-1:0] r_total;
    logic [PW-1:0] n_head [NUM_CLASSES];
    logic [PW-1:0] n_tail [NUM_CLASSES];
    logic [CW-1:0] n_cnt  [NUM_CLASSES];
    logic [CW-1:0] n_total;

    logic [1:0] head_cls;
    logic [1:0] push_cls;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    // Highest nonempty class holds the head of the queue.
    always_comb begin
        if (r_cnt[CLS_VIP] != '0) begin
            head_cls = CLS_VIP;
        end else if (r_cnt[CLS_SENIOR] != '0) begin
            head_cls = CLS_SENIOR;
        end else begin
            head_cls = CLS_GENERAL;
        end
    end

    assign push_cls = (i_cmd.cls == CLS_INVALID) ? CLS_GENERAL : i_cmd.cls;

    // Each class is a ring of DEPTH entries in its own region of the memory.
    assign o_waddr = AW'(push_cls) * AW'(DEPTH) + AW'(r_tail[push_cls]);
    assign o_raddr = AW'(head_cls) * AW'(DEPTH) + AW'(r_head[head_cls]);

    assign o_flags.empty    = (r_total == '0);
    assign o_flags.full     = (r_total == CW'(DEPTH));
    assign o_flags.head_cls = head_cls;
    assign o_total          = r_total;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_cnt   = r_cnt;
        n_total = r_total;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (i_cmd.push && push_cls == 2'(c)) begin
                n_tail[c] = f_next(r_tail[c]);
                n_cnt[c]  = r_cnt[c] + CW'(1);
            end
            if (i_cmd.pop && head_cls == 2'(c)) begin
                n_head[c] = f_next(r_head[c]);
                n_cnt[c]  = r_cnt[c] - CW'(1);
            end
        end
        if (i_cmd.push) begin
            n_total = r_total + CW'(1);
        end else if (i_cmd.pop) begin
            n_total = r_total - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

    `TSPQ_ASSERT_NOW(a_count_sum, i_clk, i_rst_n, 1'b1, ({2'b00, r_cnt[CLS_GENERAL]} + {2'b00, r_cnt[CLS_SENIOR]} + {2'b00, r_cnt[CLS_VIP]}) == {2'b00, r_total})
    `TSPQ_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= CW'(DEPTH))
    `TSPQ_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_cnt[head_cls] != '0 && !i_cmd.push)

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tspq_pkg::*;

    localparam int QUEUE_DEPTH  = 128;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic        action;
        logic [15:0] id;
        logic [1:0]  cls;
    } t_request;

    typedef struct {
        logic [1:0]  cls;
        logic [15:0] id;
    } t_entry;

    typedef struct {
        t_status     status;
        logic [15:0] id;
        logic [1:0]  cls;
        logic [7:0]  occ;
    } t_result;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [15:0] i_entry_id;
    logic [1:0]  i_entry_class;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [15:0] o_served_id;
    logic [1:0]  o_served_class;
    logic [7:0]  o_occupancy;

    t_request    pending_items[$];
    t_result     expected_results[$];
    t_entry      waiting_entries[$];

    t_request    next_req;
    t_result     want;
    bit          item_taken = 0;
    bit          activity;
    int          err_count = 0;
    int          result_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          holdoff_left = 0;
    int          holds_taken = 0;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    three_class_stable_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_entry_id     (i_entry_id),
        .i_entry_class  (i_entry_class),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_served_id    (o_served_id),
        .o_served_class (o_served_class),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Highest class first, arrival order kept within a class.
    function automatic t_result predict_result(logic action, logic [15:0] id, logic [1:0] cls);
        t_result r;
        t_entry  e;
        int      pos;
        r.status = ST_ENQUEUED;
        r.id     = '0;
        r.cls    = '0;
        if (action == ACT_ENQ) begin
            if (cls == CLS_INVALID) begin
                r.status = ST_INVALID;
            end else if (waiting_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < waiting_entries.size() && waiting_entries[pos].cls >= cls)
                    pos++;
                e.cls = cls;
                e.id  = id;
                waiting_entries.insert(pos, e);
                r.status = ST_ENQUEUED;
            end
        end else if (waiting_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e        = waiting_entries.pop_front();
            r.status = ST_SERVED;
            r.id     = e.id;
            r.cls    = e.cls;
        end
        r.occ = 8'(waiting_entries.size());
        return r;
    endfunction

    function automatic void add_request(logic action, logic [15:0] id, logic [1:0] cls);
        t_request req;
        req.action = action;
        req.id     = id;
        req.cls    = cls;
        pending_items.push_back(req);
    endfunction

    // Invalid class kept rare so fill phases actually reach the full store.
    function automatic void add_phase(int count, int enq_pct);
        logic [1:0] cls;
        for (int n = 0; n < count; n++) begin
            cls = ($urandom_range(19) == 0) ? CLS_INVALID : 2'($urandom_range(2));
            add_request(($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ,
                        16'($urandom), cls);
        end
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_action      = ACT_ENQ;
        i_entry_id    = '0;
        i_entry_class = CLS_GENERAL;

        add_request(ACT_DEQ, 16'hFFFF, CLS_INVALID);
        add_request(ACT_ENQ, 16'h0000, CLS_GENERAL);
        add_request(ACT_ENQ, 16'hFFFF, CLS_VIP);
        add_request(ACT_ENQ, 16'h1234, CLS_SENIOR);
        add_request(ACT_ENQ, 16'h0001, CLS_GENERAL);
        add_request(ACT_ENQ, 16'hAAAA, CLS_VIP);
        add_request(ACT_ENQ, 16'h5555, CLS_INVALID);
        add_request(ACT_ENQ, 16'h5555, CLS_SENIOR);
        for (int n = 0; n < 6; n++)
            add_request(ACT_DEQ, 16'h0000, CLS_GENERAL);
        add_request(ACT_DEQ, 16'h0000, CLS_GENERAL);
        add_request(ACT_ENQ, 16'hFFFF, CLS_INVALID);
        add_request(ACT_ENQ, 16'h8000, CLS_VIP);
        add_request(ACT_DEQ, 16'h7FFF, CLS_VIP);

        add_phase(200, 98);
        add_phase(100, 50);
        add_phase(60, 80);
        add_phase(220, 2);
        for (int p = 0; p < 4; p++)
            add_phase($urandom_range(40, 80), $urandom_range(20, 80));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || item_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_req = pending_items.pop_front();
                    i_action      <= next_req.action;
                    i_entry_id    <= next_req.id;
                    i_entry_class <= next_req.cls;
                    i_in_valid    <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            item_taken = 0;
        end
    end

    // Receiver: changing stall pattern, plus two long hold-offs mid-stream.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else if ((holds_taken == 0 && result_count >= 150) ||
                     (holds_taken == 1 && result_count >= 600)) begin
            holds_taken++;
            holdoff_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(3));
                mode_left  = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(7) == 0);
                STALL_HEAVY:    i_out_stall <= 1'($urandom_range(1));
                default:        i_out_stall <= (mode_left % 5 < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            activity = 0;
            if (o_out_valid && !i_out_stall) begin
                activity = 1;
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d", o_status);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        err_count++;
                    end
                    if (o_served_id !== want.id) begin
                        $error("served_id: expected %0h, actual %0h", want.id, o_served_id);
                        err_count++;
                    end
                    if (o_served_class !== want.cls) begin
                        $error("served_class: expected %0d, actual %0d",
                               want.cls, o_served_class);
                        err_count++;
                    end
                    if (o_occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, actual %0d", want.occ, o_occupancy);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                activity = 1;
                expected_results.push_back(predict_result(i_action, i_entry_id, i_entry_class));
                item_taken = 1;
            end
            if (activity) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("tb: errors");
                    $finish;
                end
            end
        end
    end

endmodule
